[rtl/lacf_pkg.sv]
`default_nettype none

package lacf_pkg;

    localparam int unsigned NUM_SIDES = 4;

    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_WEST  = 2'd2;
    localparam logic [1:0] SIDE_EAST  = 2'd3;

    localparam logic [1:0] ARROW_ABSENT = 2'd0;
    localparam logic [1:0] ARROW_EMPTY  = 2'd1;
    localparam logic [1:0] ARROW_TOK0   = 2'd2;
    localparam logic [1:0] ARROW_TOK1   = 2'd3;

    localparam logic [3:0] CELL_AND       = 4'd0;
    localparam logic [3:0] CELL_OR        = 4'd1;
    localparam logic [3:0] CELL_XOR       = 4'd2;
    localparam logic [3:0] CELL_NAND      = 4'd3;
    localparam logic [3:0] CELL_SINK      = 4'd4;
    localparam logic [3:0] CELL_FILE      = 4'd5;
    localparam logic [3:0] CELL_WIRE      = 4'd6;
    localparam logic [3:0] CELL_CROSSOVER = 4'd7;
    localparam logic [3:0] CELL_COPY_N    = 4'd8;
    localparam logic [3:0] CELL_COPY_E    = 4'd11;
    localparam logic [3:0] CELL_DELETE_N  = 4'd12;
    localparam logic [3:0] CELL_DELETE_E  = 4'd15;

    localparam logic [1:0] FILE_NONE = 2'd0;
    localparam logic [1:0] FILE_BYTE = 2'd1;
    localparam logic [1:0] FILE_EOF  = 2'd2;

    localparam logic [7:0] CHAR_LF   = 8'd10;
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_ZERO = 8'd48;

    localparam logic REG_SIDE_EN = 1'b0;

    typedef logic [NUM_SIDES-1:0][1:0] t_arrows;

    typedef struct packed {
        logic [3:0] cell_type;
        t_arrows    in_arrow;
        t_arrows    out_arrow;
        logic [7:0] file_byte;
        logic [1:0] file_status;
    } t_cell_item;

    typedef struct packed {
        logic    fired;
        t_arrows new_in;
        t_arrows new_out;
        logic    file_read;
    } t_cell_result;

endpackage

`default_nettype wire

[rtl/lacf_cfg.sv]
`default_nettype none

module lacf_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             o_side_en
);

    logic r_side_en;
    logic n_side_en;
    logic w_wr_en;

    assign pready  = 1'b1;
    assign w_wr_en = psel && penable && pwrite && (paddr[2] == lacf_pkg::REG_SIDE_EN);

    always_comb begin
        n_side_en = r_side_en;
        if (w_wr_en) begin
            n_side_en = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_en <= 1'b0;
        end else begin
            r_side_en <= n_side_en;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == lacf_pkg::REG_SIDE_EN) begin
            prdata = {31'd0, r_side_en};
        end
    end

    assign o_side_en = r_side_en;

endmodule

`default_nettype wire

[rtl/lacf_fire.sv]
`default_nettype none

module lacf_fire (
    input  wire lacf_pkg::t_cell_item i_item,
    input  wire logic                 i_side_en,
    output lacf_pkg::t_cell_result    o_result
);

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_DONE,
        MODE_NORMAL
    } t_mode;

    t_mode             mode;
    lacf_pkg::t_arrows ai;
    lacf_pkg::t_arrows ao;
    logic [3:0]        in_tok;
    logic [3:0]        in_val;
    logic [3:0]        in_empty;
    logic [3:0]        out_tok;
    logic [1:0]        dir;
    logic [3:0]        dir_mask;
    logic [3:0]        ctl_tok;
    logic              ctl_one;
    logic [1:0]        cdir;
    logic              ctl_val;
    logic              res;
    logic              fired;
    logic              fread;
    logic              keep_en;
    logic              wire_found;
    logic              wire_val;
    logic [7:0]        digit;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_tok[i]   = i_item.in_arrow[i][1];
            in_val[i]   = i_item.in_arrow[i][0];
            in_empty[i] = (i_item.in_arrow[i] == lacf_pkg::ARROW_EMPTY);
            out_tok[i]  = i_item.out_arrow[i][1];
        end
    end

    assign dir      = i_item.cell_type[1:0];
    assign dir_mask = 4'b0001 << dir;
    assign ctl_tok  = in_tok & ~dir_mask;
    assign ctl_one  = |(ctl_tok & in_val);
    assign digit    = i_item.file_byte - lacf_pkg::CHAR_ZERO;

    always_comb begin
        cdir       = 2'd0;
        ctl_val    = 1'b0;
        wire_found = 1'b0;
        wire_val   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (ctl_tok[i]) begin
                cdir    = 2'(i);
                ctl_val = in_val[i];
            end
            if (in_tok[i]) begin
                wire_found = 1'b1;
                wire_val   = in_val[i];
            end
        end
    end

    always_comb begin
        ai      = i_item.in_arrow;
        ao      = i_item.out_arrow;
        mode    = MODE_NORMAL;
        res     = 1'b0;
        fired   = 1'b0;
        fread   = 1'b0;
        keep_en = 1'b0;
        unique case (i_item.cell_type) inside
            lacf_pkg::CELL_AND, lacf_pkg::CELL_NAND: begin
                res = &(~in_tok | in_val);
                if (i_item.cell_type == lacf_pkg::CELL_NAND) begin
                    res = ~res;
                end
                if (|in_empty) begin
                    mode = MODE_HOLD;
                end
            end
            lacf_pkg::CELL_OR: begin
                res = |(in_tok & in_val);
                if (|in_empty) begin
                    mode = MODE_HOLD;
                end
            end
            lacf_pkg::CELL_XOR: begin
                res = ^(in_tok & in_val);
                if (|in_empty) begin
                    mode = MODE_HOLD;
                end
            end
            lacf_pkg::CELL_SINK: begin
                res = 1'b0;
            end
            lacf_pkg::CELL_FILE: begin
                if (!i_side_en || !((i_item.file_status == lacf_pkg::FILE_BYTE) ||
                                    (i_item.file_status == lacf_pkg::FILE_EOF))) begin
                    mode = MODE_HOLD;
                end else begin
                    fread = 1'b1;
                    res   = digit[0];
                    if ((i_item.file_status == lacf_pkg::FILE_EOF) ||
                        (i_item.file_byte == lacf_pkg::CHAR_CR) ||
                        (i_item.file_byte == lacf_pkg::CHAR_LF)) begin
                        mode = MODE_HOLD;
                    end
                end
            end
            lacf_pkg::CELL_WIRE: begin
                res = wire_val;
                if (!wire_found) begin
                    mode = MODE_HOLD;
                end
            end
            lacf_pkg::CELL_CROSSOVER: begin
                mode = MODE_DONE;
                for (int i = 0; i < 4; i++) begin
                    if (in_tok[i] && (i_item.out_arrow[i ^ 1] == lacf_pkg::ARROW_EMPTY)) begin
                        ao[i ^ 1] = i_item.in_arrow[i];
                        ai[i]     = lacf_pkg::ARROW_EMPTY;
                        fired     = 1'b1;
                    end
                end
            end
            [lacf_pkg::CELL_COPY_N:lacf_pkg::CELL_COPY_E]: begin
                res     = in_val[dir];
                keep_en = ctl_one;
                if (!(in_tok[dir] && |ctl_tok)) begin
                    mode = MODE_HOLD;
                end
            end
            [lacf_pkg::CELL_DELETE_N:lacf_pkg::CELL_DELETE_E]: begin
                res = in_val[dir];
                if (!(in_tok[dir] && |ctl_tok)) begin
                    mode = MODE_HOLD;
                end else if (ctl_val) begin
                    ai[dir]  = lacf_pkg::ARROW_EMPTY;
                    ai[cdir] = lacf_pkg::ARROW_EMPTY;
                    fired    = 1'b1;
                    mode     = MODE_DONE;
                end
            end
            default: begin
                mode = MODE_HOLD;
            end
        endcase

        if ((mode == MODE_NORMAL) && |out_tok) begin
            mode = MODE_HOLD;
        end
        if (mode == MODE_NORMAL) begin
            for (int i = 0; i < 4; i++) begin
                if (i_item.out_arrow[i] != lacf_pkg::ARROW_ABSENT) begin
                    ao[i] = {1'b1, res};
                end
                if (in_tok[i] && !(keep_en && (2'(i) == dir))) begin
                    ai[i] = lacf_pkg::ARROW_EMPTY;
                end
            end
            fired = 1'b1;
        end
    end

    assign o_result.fired     = fired;
    assign o_result.new_in    = ai;
    assign o_result.new_out   = ao;
    assign o_result.file_read = fread;

endmodule

`default_nettype wire

[rtl/logic_automaton_cell_fire_unit.sv]
// An accepted input word is held in the input register, which feeds the firing logic;
// the result word is held in the output register until the consumer takes it.
// Throughput: one word per cycle while the consumer does not stall.
// Reset: synchronous, active low; clears both valid flags and the side-effects
// enable register. No clearing pass is needed.
`default_nettype none

module logic_automaton_cell_fire_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_cell_type,
    input  wire logic [1:0]  i_in_north,
    input  wire logic [1:0]  i_in_south,
    input  wire logic [1:0]  i_in_west,
    input  wire logic [1:0]  i_in_east,
    input  wire logic [1:0]  i_out_north,
    input  wire logic [1:0]  i_out_south,
    input  wire logic [1:0]  i_out_west,
    input  wire logic [1:0]  i_out_east,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic [1:0]  i_file_status,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_fired,
    output logic      [1:0]  o_new_in_north,
    output logic      [1:0]  o_new_in_south,
    output logic      [1:0]  o_new_in_west,
    output logic      [1:0]  o_new_in_east,
    output logic      [1:0]  o_new_out_north,
    output logic      [1:0]  o_new_out_south,
    output logic      [1:0]  o_new_out_west,
    output logic      [1:0]  o_new_out_east,
    output logic             o_file_read
);

    logic                   w_side_en;
    logic                   r_s1_valid;
    logic                   n_s1_valid;
    logic                   r_s2_valid;
    logic                   n_s2_valid;
    logic                   w_s2_load;
    logic                   w_s1_load;
    lacf_pkg::t_cell_item   r_item;
    lacf_pkg::t_cell_item   w_item;
    lacf_pkg::t_cell_result w_result;
    lacf_pkg::t_cell_result r_result;

    lacf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_side_en (w_side_en)
    );

    lacf_fire u_fire (
        .i_item    (r_item),
        .i_side_en (w_side_en),
        .o_result  (w_result)
    );

    always_comb begin
        w_item.cell_type                      = i_cell_type;
        w_item.in_arrow[lacf_pkg::SIDE_NORTH]  = i_in_north;
        w_item.in_arrow[lacf_pkg::SIDE_SOUTH]  = i_in_south;
        w_item.in_arrow[lacf_pkg::SIDE_WEST]   = i_in_west;
        w_item.in_arrow[lacf_pkg::SIDE_EAST]   = i_in_east;
        w_item.out_arrow[lacf_pkg::SIDE_NORTH] = i_out_north;
        w_item.out_arrow[lacf_pkg::SIDE_SOUTH] = i_out_south;
        w_item.out_arrow[lacf_pkg::SIDE_WEST]  = i_out_west;
        w_item.out_arrow[lacf_pkg::SIDE_EAST]  = i_out_east;
        w_item.file_byte                      = i_file_byte;
        w_item.file_status                    = i_file_status;
    end

    assign w_s2_load  = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s2_load;
    assign w_s1_load  = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_in_ready) begin
            n_s1_valid = i_in_valid;
        end
        n_s2_valid = r_s2_valid;
        if (!r_s2_valid || i_out_ready) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_item <= w_item;
        end
        if (w_s2_load) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_s2_valid;
    assign o_fired         = r_result.fired;
    assign o_new_in_north  = r_result.new_in[lacf_pkg::SIDE_NORTH];
    assign o_new_in_south  = r_result.new_in[lacf_pkg::SIDE_SOUTH];
    assign o_new_in_west   = r_result.new_in[lacf_pkg::SIDE_WEST];
    assign o_new_in_east   = r_result.new_in[lacf_pkg::SIDE_EAST];
    assign o_new_out_north = r_result.new_out[lacf_pkg::SIDE_NORTH];
    assign o_new_out_south = r_result.new_out[lacf_pkg::SIDE_SOUTH];
    assign o_new_out_west  = r_result.new_out[lacf_pkg::SIDE_WEST];
    assign o_new_out_east  = r_result.new_out[lacf_pkg::SIDE_EAST];
    assign o_file_read     = r_result.file_read;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("accepted word did not reach the input register");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result word appeared without a word in the input register");

    a_read_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_file_read) |-> w_side_en)
        else $error("file read reported while side effects are disabled");

endmodule

`default_nettype wire

[verif/tb_logic_automaton_cell_fire_unit.sv]
`timescale 1ns / 100ps

module tb_logic_automaton_cell_fire_unit;
    import lacf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned WORDS_PER_PHASE = 160;
    localparam int unsigned NUM_PHASES = 4;
    localparam int unsigned DUT_LATENCY = 2;
    localparam logic [2:0] ADDR_SIDE_EN = {REG_SIDE_EN, 2'b00};
    localparam logic [1:0] FILE_UNKNOWN = 2'd3;

    localparam logic [1:0] AB = ARROW_ABSENT;
    localparam logic [1:0] EM = ARROW_EMPTY;
    localparam logic [1:0] T0 = ARROW_TOK0;
    localparam logic [1:0] T1 = ARROW_TOK1;

    class cell_fire_scoreboard;
        typedef enum {FIRE_HOLD, FIRE_DONE, FIRE_NORMAL} fire_mode_e;

        logic         side_en;
        t_cell_result pending[$];
        int           errors;

        function new();
            side_en = 1'b0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function t_cell_result fire_cell(t_cell_item c);
            t_arrows    ai;
            t_arrows    ao;
            fire_mode_e mode;
            logic       res;
            logic       fired;
            logic       fread;
            logic       go;
            logic       ctl;
            logic [7:0] diff;
            int         keep;
            int         dir;
            int         cdir;
            ai = c.in_arrow;
            ao = c.out_arrow;
            mode = FIRE_NORMAL;
            res = 1'b0;
            fired = 1'b0;
            fread = 1'b0;
            go = 1'b0;
            ctl = 1'b0;
            keep = -1;
            cdir = 0;
            if (c.cell_type <= CELL_NAND) begin
                res = (c.cell_type == CELL_AND || c.cell_type == CELL_NAND);
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (ai[s] == ARROW_EMPTY) begin
                        mode = FIRE_HOLD;
                    end else if (ai[s][1]) begin
                        case (c.cell_type)
                            CELL_OR: res = res | ai[s][0];
                            CELL_XOR: res = res ^ ai[s][0];
                            default: res = res & ai[s][0];
                        endcase
                    end
                end
                if (c.cell_type == CELL_NAND) res = ~res;
            end else if (c.cell_type == CELL_SINK) begin
                res = 1'b0;
            end else if (c.cell_type == CELL_FILE) begin
                if (!((c.file_status == FILE_BYTE || c.file_status == FILE_EOF) && side_en)) begin
                    mode = FIRE_HOLD;
                end else begin
                    fread = 1'b1;
                    if (c.file_status == FILE_EOF || c.file_byte == CHAR_CR
                            || c.file_byte == CHAR_LF) begin
                        mode = FIRE_HOLD;
                    end else begin
                        diff = c.file_byte - CHAR_ZERO;
                        res = diff[0];
                    end
                end
            end else if (c.cell_type == CELL_WIRE) begin
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (ai[s][1]) begin
                        res = ai[s][0];
                        go = 1'b1;
                    end
                end
                if (!go) mode = FIRE_HOLD;
            end else if (c.cell_type == CELL_CROSSOVER) begin
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (ai[s][1] && ao[s ^ 1] == ARROW_EMPTY) begin
                        ao[s ^ 1] = ai[s];
                        ai[s] = ARROW_EMPTY;
                        fired = 1'b1;
                    end
                end
                mode = FIRE_DONE;
            end else if (c.cell_type <= CELL_COPY_E) begin
                dir = c.cell_type - CELL_COPY_N;
                if (ai[dir][1]) begin
                    for (int s = 0; s < NUM_SIDES; s++) begin
                        if (s != dir && ai[s][1]) begin
                            go = 1'b1;
                            res = ai[dir][0];
                            if (ai[s][0]) keep = dir;
                        end
                    end
                end
                if (!go) mode = FIRE_HOLD;
            end else begin
                dir = c.cell_type - CELL_DELETE_N;
                if (ai[dir][1]) begin
                    for (int s = 0; s < NUM_SIDES; s++) begin
                        if (s != dir && ai[s][1]) begin
                            cdir = s;
                            go = 1'b1;
                            ctl = ai[s][0];
                        end
                    end
                end
                if (!go) begin
                    mode = FIRE_HOLD;
                end else if (ctl) begin
                    ai[dir] = ARROW_EMPTY;
                    ai[cdir] = ARROW_EMPTY;
                    fired = 1'b1;
                    mode = FIRE_DONE;
                end else begin
                    res = ai[dir][0];
                end
            end

            if (mode == FIRE_NORMAL) begin
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (ao[s][1]) mode = FIRE_HOLD;
                end
            end
            if (mode == FIRE_NORMAL) begin
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (ao[s] != ARROW_ABSENT) ao[s] = {1'b1, res};
                    if (ai[s][1] && s != keep) ai[s] = ARROW_EMPTY;
                end
                fired = 1'b1;
            end
            return {fired, ai, ao, fread};
        endfunction

        function void note_cell(t_cell_item c);
            pending.push_back(fire_cell(c));
        endfunction

        task check_result(t_cell_result got);
            t_cell_result want;
            if (pending.size() == 0) begin
                report($sformatf("result word %h with no cell pending", got));
            end else begin
                want = pending.pop_front();
                if (got.fired !== want.fired)
                    report($sformatf("fired got %b expected %b", got.fired, want.fired));
                if (got.file_read !== want.file_read)
                    report($sformatf("file_read got %b expected %b",
                                     got.file_read, want.file_read));
                for (int s = 0; s < NUM_SIDES; s++) begin
                    if (got.new_in[s] !== want.new_in[s])
                        report($sformatf("new_in side %0d got %0d expected %0d",
                                         s, got.new_in[s], want.new_in[s]));
                    if (got.new_out[s] !== want.new_out[s])
                        report($sformatf("new_out side %0d got %0d expected %0d",
                                         s, got.new_out[s], want.new_out[s]));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_cell_type;
    logic [1:0]  i_in_north;
    logic [1:0]  i_in_south;
    logic [1:0]  i_in_west;
    logic [1:0]  i_in_east;
    logic [1:0]  i_out_north;
    logic [1:0]  i_out_south;
    logic [1:0]  i_out_west;
    logic [1:0]  i_out_east;
    logic [7:0]  i_file_byte;
    logic [1:0]  i_file_status;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_fired;
    logic [1:0]  o_new_in_north;
    logic [1:0]  o_new_in_south;
    logic [1:0]  o_new_in_west;
    logic [1:0]  o_new_in_east;
    logic [1:0]  o_new_out_north;
    logic [1:0]  o_new_out_south;
    logic [1:0]  o_new_out_west;
    logic [1:0]  o_new_out_east;
    logic        o_file_read;

    cell_fire_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic_automaton_cell_fire_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cell_type(i_cell_type),
        .i_in_north(i_in_north),
        .i_in_south(i_in_south),
        .i_in_west(i_in_west),
        .i_in_east(i_in_east),
        .i_out_north(i_out_north),
        .i_out_south(i_out_south),
        .i_out_west(i_out_west),
        .i_out_east(i_out_east),
        .i_file_byte(i_file_byte),
        .i_file_status(i_file_status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_fired(o_fired),
        .o_new_in_north(o_new_in_north),
        .o_new_in_south(o_new_in_south),
        .o_new_in_west(o_new_in_west),
        .o_new_in_east(o_new_in_east),
        .o_new_out_north(o_new_out_north),
        .o_new_out_south(o_new_out_south),
        .o_new_out_west(o_new_out_west),
        .o_new_out_east(o_new_out_east),
        .o_file_read(o_file_read)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_cell(t_cell_item'({i_cell_type,
                                       i_in_east, i_in_west, i_in_south, i_in_north,
                                       i_out_east, i_out_west, i_out_south, i_out_north,
                                       i_file_byte, i_file_status}));
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(t_cell_result'({o_fired,
                                            o_new_in_east, o_new_in_west,
                                            o_new_in_south, o_new_in_north,
                                            o_new_out_east, o_new_out_west,
                                            o_new_out_south, o_new_out_north,
                                            o_file_read}));
    end

    function automatic t_arrows arw(logic [1:0] n, logic [1:0] s, logic [1:0] w,
                                    logic [1:0] e);
        return {e, w, s, n};
    endfunction

    function automatic t_cell_item mk(logic [3:0] t, t_arrows ai, t_arrows ao,
                                      logic [7:0] b, logic [1:0] st);
        return {t, ai, ao, b, st};
    endfunction

    function automatic logic [1:0] rand_arrow(bit is_input, bit clean);
        int unsigned r;
        r = $urandom_range(9);
        if (!clean) return 2'($urandom_range(3));
        if (is_input) begin
            if (r == 0) return ARROW_EMPTY;
            if (r <= 3) return ARROW_ABSENT;
            return {1'b1, 1'($urandom_range(1))};
        end
        if (r == 0) return {1'b1, 1'($urandom_range(1))};
        if (r <= 4) return ARROW_ABSENT;
        return ARROW_EMPTY;
    endfunction

    function automatic t_cell_item rand_cell();
        t_cell_item c;
        bit         clean;
        clean = ($urandom_range(99) < 80);
        c.cell_type = 4'($urandom_range(15));
        for (int s = 0; s < NUM_SIDES; s++) begin
            c.in_arrow[s] = rand_arrow(1'b1, clean);
            c.out_arrow[s] = rand_arrow(1'b0, clean);
        end
        case ($urandom_range(3))
            0: c.file_byte = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            1: c.file_byte = 8'(CHAR_ZERO + $urandom_range(1));
            default: c.file_byte = 8'($urandom_range(255));
        endcase
        if (clean)
            c.file_status = ($urandom_range(9) == 0) ? FILE_EOF : FILE_BYTE;
        else
            c.file_status = 2'($urandom_range(3));
        return c;
    endfunction

    task automatic send_word(t_cell_item w);
        i_in_valid <= 1'b1;
        i_cell_type <= w.cell_type;
        i_in_north <= w.in_arrow[SIDE_NORTH];
        i_in_south <= w.in_arrow[SIDE_SOUTH];
        i_in_west <= w.in_arrow[SIDE_WEST];
        i_in_east <= w.in_arrow[SIDE_EAST];
        i_out_north <= w.out_arrow[SIDE_NORTH];
        i_out_south <= w.out_arrow[SIDE_SOUTH];
        i_out_west <= w.out_arrow[SIDE_WEST];
        i_out_east <= w.out_arrow[SIDE_EAST];
        i_file_byte <= w.file_byte;
        i_file_status <= w.file_status;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DUT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_side_en(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_SIDE_EN;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.side_en = value[0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        int unsigned idle_tab[NUM_PHASES];
        int unsigned stall_tab[NUM_PHASES];
        logic [31:0] en_tab[NUM_PHASES];
        idle_tab = '{0, 72, 0, 31};
        stall_tab = '{0, 0, 72, 31};
        en_tab = '{32'd1, 32'd0, 32'd1, 32'd1};

        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_cell_type <= '0;
        i_in_north <= '0;
        i_in_south <= '0;
        i_in_west <= '0;
        i_in_east <= '0;
        i_out_north <= '0;
        i_out_south <= '0;
        i_out_west <= '0;
        i_out_east <= '0;
        i_file_byte <= '0;
        i_file_status <= '0;
        i_out_ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // File cells stay quiet while side effects are disabled after reset.
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, EM, EM, EM), 8'd49, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(T1, AB, AB, AB), arw(EM, AB, AB, AB), 8'd48, FILE_EOF));
        drain();
        write_side_en(32'd1);

        send_word(mk(CELL_AND, arw(T1, T1, T1, T1), arw(EM, EM, EM, EM), 8'h00, FILE_NONE));
        send_word(mk(CELL_AND, arw(T1, EM, T0, AB), arw(EM, AB, EM, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_AND, arw(AB, AB, AB, AB), arw(EM, EM, AB, EM), 8'hFF, FILE_EOF));
        send_word(mk(CELL_OR, arw(T0, AB, T1, AB), arw(AB, EM, AB, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_XOR, arw(T1, T1, T1, AB), arw(EM, EM, EM, EM), 8'h00, FILE_NONE));
        send_word(mk(CELL_NAND, arw(T1, T1, T1, T1), arw(EM, EM, EM, EM), 8'h00, FILE_NONE));
        send_word(mk(CELL_NAND, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_OR, arw(T1, AB, AB, AB), arw(EM, T0, AB, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_SINK, arw(T1, T0, EM, AB), arw(EM, AB, AB, EM), 8'h00, FILE_NONE));
        send_word(mk(CELL_SINK, arw(T1, AB, AB, AB), arw(EM, AB, AB, T1), 8'h00, FILE_NONE));
        send_word(mk(CELL_FILE, arw(T0, AB, AB, AB), arw(EM, EM, EM, EM), 8'd49, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), CHAR_CR, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), CHAR_LF, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), 8'd49, FILE_EOF));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), 8'd49, FILE_NONE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, AB, AB, AB), 8'd49,
                     FILE_UNKNOWN));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(AB, EM, EM, AB), 8'h00, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, EM, AB, EM), 8'hFF, FILE_BYTE));
        send_word(mk(CELL_FILE, arw(AB, AB, AB, AB), arw(EM, T0, AB, AB), 8'd49, FILE_BYTE));
        send_word(mk(CELL_WIRE, arw(T0, EM, T1, AB), arw(EM, EM, AB, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_WIRE, arw(EM, EM, AB, AB), arw(EM, EM, AB, AB), 8'h00, FILE_NONE));
        send_word(mk(CELL_CROSSOVER, arw(T1, T0, T1, AB), arw(EM, T1, EM, EM), 8'h00,
                     FILE_NONE));
        send_word(mk(CELL_COPY_N, arw(T0, AB, T1, AB), arw(AB, EM, AB, EM), 8'h00, FILE_NONE));
        send_word(mk(CELL_COPY_E, arw(T0, AB, AB, T1), arw(EM, EM, EM, AB), 8'h00, FILE_NONE));
        send_word(mk(4'(CELL_COPY_N + SIDE_SOUTH), arw(AB, T1, EM, AB), arw(EM, AB, AB, AB),
                     8'h00, FILE_NONE));
        send_word(mk(CELL_DELETE_N, arw(T0, T0, AB, T1), arw(T1, EM, AB, AB), 8'h00,
                     FILE_NONE));
        send_word(mk(4'(CELL_DELETE_N + SIDE_WEST), arw(T1, AB, T1, T0), arw(EM, EM, AB, EM),
                     8'h00, FILE_NONE));
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            write_side_en(en_tab[p]);
            repeat (WORDS_PER_PHASE) send_word(rand_cell());
            drain();
        end

        repeat (DUT_LATENCY + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/lacf_pkg.sv
rtl/lacf_cfg.sv
rtl/lacf_fire.sv
rtl/logic_automaton_cell_fire_unit.sv
verif/tb_logic_automaton_cell_fire_unit.sv
